### hw/rtl/gapf_pkg.sv
// ----------------------------------------------------------------------------
// gapf_pkg
// Shared constants for the articulation point finder: default sizes and the
// operation, status and visit mark codes.
// ----------------------------------------------------------------------------
package gapf_pkg;

  localparam int unsigned MaxNodesDefault = 1024;
  localparam int unsigned MaxEdgesDefault = 4096;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_ADD     = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;
  localparam logic [1:0] OP_QUERY   = 2'd3;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_RANGE  = 2'd2;
  localparam logic [1:0] STAT_NOCOMP = 2'd3;

  localparam logic [1:0] MK_FREE = 2'd0;
  localparam logic [1:0] MK_VIS  = 2'd1;
  localparam logic [1:0] MK_ART  = 2'd2;

endpackage

### hw/rtl/graph_articulation_point_finder_core.sv
// ----------------------------------------------------------------------------
// graph_articulation_point_finder_core
// Edge store, depth-first walk and per-node query for articulation points.
// ----------------------------------------------------------------------------
// Items are taken one at a time. An edge load does two list head
// read-modify-writes in the head memory, a query one node memory read, a
// clear a pass over the head memory, and a compute a walk over the active
// nodes, their stored adjacency entries and tree edges, where every walk step
// is a dependent read of the edge memory and the node memory. After reset the
// head memory is cleared before the first word is taken.
module graph_articulation_point_finder_core #(
  parameter int unsigned MAX_NODES = gapf_pkg::MaxNodesDefault,
  parameter int unsigned MAX_EDGES = gapf_pkg::MaxEdgesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [10:0] node_a_i,
  input  logic [10:0] node_b_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [10:0] component_count_o,
  output logic [10:0] articulation_count_o,
  output logic        is_component_root_o,
  output logic        is_articulation_o
);

  localparam int unsigned NW    = $clog2(MAX_NODES + 1);
  localparam int unsigned NCW   = (NW > 11) ? NW : 11;
  localparam int unsigned SLOTS = 2 * MAX_EDGES;
  localparam int unsigned PW    = $clog2(SLOTS + 1);
  localparam int unsigned EAW   = $clog2(SLOTS);
  localparam int unsigned SAW   = $clog2(MAX_NODES);
  localparam int unsigned EW    = NW + PW;
  localparam int unsigned NEW   = 3 + 2 * NW;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_ADD1, ST_ADD2, ST_ADD3, ST_SWEEP, ST_S0, ST_S1,
    ST_E0, ST_E1, ST_E2, ST_P1, ST_P2, ST_QRY, ST_DONE
  } state_e;

  state_e state_q;

  logic [10:0]  node_count_q;
  logic         computed_q, clr_resp_q, out_valid_q;
  logic [PW-1:0] fill_q, p_q;
  logic [NW-1:0] comp_q, art_q, r_q, a_q, b_q, v_q, w_q, dv_q, lv_q, clow_q;
  logic [1:0]   mk_q, rc_q;
  logic         rt_q;
  logic [SAW-1:0] sp_q;
  logic [1:0]   res_status_q;
  logic         res_root_q, res_art_q;
  logic [1:0]   status_q;
  logic [10:0]  ccount_q, acount_q;
  logic         oroot_q, oart_q;

  // memories
  logic [EW-1:0]  edge_mem [SLOTS];
  logic [PW-1:0]  head_mem [MAX_NODES + 1];
  logic [NEW-1:0] node_mem [MAX_NODES + 1];
  logic [EW-1:0]  stack_mem [MAX_NODES];

  logic           e_we, e_re, h_we, h_re, n_we, n_re, s_we, s_re;
  logic [EAW-1:0] e_wa, e_ra;
  logic [EW-1:0]  e_wd, e_rd;
  logic [NW-1:0]  h_wa, h_ra, n_wa, n_ra;
  logic [PW-1:0]  h_wd, h_rd;
  logic [NEW-1:0] n_wd, n_rd;
  logic [SAW-1:0] s_wa, s_ra;
  logic [EW-1:0]  s_wd, s_rd;

  always_ff @(posedge clk_i) begin
    if (e_we) edge_mem[e_wa] <= e_wd;
    if (e_re) e_rd <= edge_mem[e_ra];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) head_mem[h_wa] <= h_wd;
    if (h_re) h_rd <= head_mem[h_ra];
  end

  always_ff @(posedge clk_i) begin
    if (n_we) node_mem[n_wa] <= n_wd;
    if (n_re) n_rd <= node_mem[n_ra];
  end

  always_ff @(posedge clk_i) begin
    if (s_we) stack_mem[s_wa] <= s_wd;
    if (s_re) s_rd <= stack_mem[s_ra];
  end

  // decoded fields
  logic [NCW-1:0] n_eff;
  logic [NW-1:0]  n_nw;
  logic           in_fire, a_ok, b_ok, fill_full;
  logic [NW-1:0]  e_nb, w_dep, nr_dep, nr_low;
  logic [PW-1:0]  e_link;
  logic [1:0]     nr_mark, w_mark, root_mark;
  logic           nr_root, w_ok, self_w, p_empty, st_full, do_push;
  logic [PW:0]    fill_next;

  always_comb begin
    n_eff = (NCW'(node_count_q) > NCW'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(node_count_q);
    n_nw  = NW'(n_eff);
  end

  assign in_fire   = in_valid_i && (state_q == ST_IDLE);
  assign a_ok      = (node_a_i != 11'd0) && (NCW'(node_a_i) <= n_eff);
  assign b_ok      = (node_b_i != 11'd0) && (NCW'(node_b_i) <= n_eff);
  assign fill_next = {1'b0, fill_q} + (PW + 1)'(2);
  assign fill_full = fill_next > (PW + 1)'(SLOTS);

  assign e_nb    = e_rd[PW +: NW];
  assign e_link  = e_rd[PW-1:0];
  assign w_ok    = (e_nb != '0) && (e_nb <= n_nw);
  assign nr_mark = n_rd[NEW-1 -: 2];
  assign nr_root = n_rd[2*NW];
  assign nr_dep  = n_rd[NW +: NW];
  assign nr_low  = n_rd[NW-1:0];

  // forward the top entry when a node lists itself
  assign self_w  = (w_q == v_q);
  assign w_mark  = self_w ? mk_q : nr_mark;
  assign w_dep   = self_w ? dv_q : nr_dep;
  assign p_empty = p_q >= PW'(SLOTS);
  assign st_full = sp_q == SAW'(MAX_NODES - 1);
  assign do_push = (w_mark == gapf_pkg::MK_FREE) && !st_full;
  assign root_mark = (rc_q[1] && mk_q == gapf_pkg::MK_VIS) ? gapf_pkg::MK_ART : mk_q;

  always_comb begin
    e_we = 1'b0; e_re = 1'b0; h_we = 1'b0; h_re = 1'b0;
    n_we = 1'b0; n_re = 1'b0; s_we = 1'b0; s_re = 1'b0;
    e_wa = '0; e_ra = '0; e_wd = '0;
    h_wa = '0; h_ra = '0; h_wd = '0;
    n_wa = '0; n_ra = '0; n_wd = '0;
    s_wa = '0; s_ra = '0; s_wd = '0;
    case (state_q)
      ST_CLR: begin
        h_we = 1'b1; h_wa = r_q; h_wd = PW'(SLOTS);
      end
      ST_IDLE: begin
        if (in_fire) begin
          h_re = 1'b1; h_ra = NW'(node_a_i);
          n_re = 1'b1; n_ra = NW'(node_a_i);
        end
      end
      ST_ADD1: begin
        e_we = 1'b1; e_wa = fill_q[EAW-1:0]; e_wd = {b_q, h_rd};
        h_we = 1'b1; h_wa = a_q; h_wd = fill_q;
      end
      ST_ADD2: begin
        h_re = 1'b1; h_ra = b_q;
      end
      ST_ADD3: begin
        e_we = 1'b1; e_wa = EAW'(fill_q + PW'(1)); e_wd = {a_q, h_rd};
        h_we = 1'b1; h_wa = b_q; h_wd = fill_q + PW'(1);
      end
      ST_SWEEP: begin
        if (r_q <= n_nw) begin
          n_we = 1'b1; n_wa = r_q; n_wd = '0;
        end
      end
      ST_S0: begin
        if (r_q <= n_nw) begin
          n_re = 1'b1; n_ra = r_q;
          h_re = 1'b1; h_ra = r_q;
        end
      end
      ST_E0: begin
        if (p_empty) begin
          if (sp_q == '0) begin
            n_we = 1'b1; n_wa = v_q; n_wd = {root_mark, rt_q, dv_q, lv_q};
          end else begin
            s_re = 1'b1; s_ra = sp_q - SAW'(1);
          end
        end else begin
          e_re = 1'b1; e_ra = p_q[EAW-1:0];
        end
      end
      ST_E1: begin
        if (w_ok) begin
          n_re = 1'b1; n_ra = e_nb;
          h_re = 1'b1; h_ra = e_nb;
        end
      end
      ST_E2: begin
        if (do_push) begin
          s_we = 1'b1; s_wa = sp_q; s_wd = {v_q, p_q};
          n_we = 1'b1; n_wa = v_q; n_wd = {mk_q, rt_q, dv_q, lv_q};
        end
      end
      ST_P1: begin
        n_re = 1'b1; n_ra = s_rd[PW +: NW];
        n_we = 1'b1; n_wa = v_q; n_wd = {mk_q, rt_q, dv_q, lv_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      node_count_q <= 11'd1;
      computed_q   <= 1'b0;
      clr_resp_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      fill_q       <= '0;
      p_q          <= '0;
      comp_q       <= '0;
      art_q        <= '0;
      r_q          <= '0;
      a_q          <= '0;
      b_q          <= '0;
      v_q          <= '0;
      w_q          <= '0;
      dv_q         <= '0;
      lv_q         <= '0;
      clow_q       <= '0;
      mk_q         <= gapf_pkg::MK_FREE;
      rc_q         <= '0;
      rt_q         <= 1'b0;
      sp_q         <= '0;
      res_status_q <= gapf_pkg::STAT_OK;
      res_root_q   <= 1'b0;
      res_art_q    <= 1'b0;
      status_q     <= gapf_pkg::STAT_OK;
      ccount_q     <= '0;
      acount_q     <= '0;
      oroot_q      <= 1'b0;
      oart_q       <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLR: begin
          if (r_q == NW'(MAX_NODES)) begin
            state_q    <= clr_resp_q ? ST_DONE : ST_IDLE;
            clr_resp_q <= 1'b0;
          end else begin
            r_q <= r_q + NW'(1);
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            a_q          <= NW'(node_a_i);
            b_q          <= NW'(node_b_i);
            res_root_q   <= 1'b0;
            res_art_q    <= 1'b0;
            case (op_i)
              gapf_pkg::OP_CLEAR: begin
                res_status_q <= gapf_pkg::STAT_OK;
                fill_q     <= '0;
                comp_q     <= '0;
                art_q      <= '0;
                computed_q <= 1'b0;
                r_q        <= '0;
                clr_resp_q <= 1'b1;
                state_q    <= ST_CLR;
              end
              gapf_pkg::OP_ADD: begin
                if (!a_ok || !b_ok) begin
                  res_status_q <= gapf_pkg::STAT_RANGE;
                  state_q      <= ST_DONE;
                end else if (fill_full) begin
                  res_status_q <= gapf_pkg::STAT_FULL;
                  state_q      <= ST_DONE;
                end else begin
                  res_status_q <= gapf_pkg::STAT_OK;
                  state_q      <= ST_ADD1;
                end
              end
              gapf_pkg::OP_COMPUTE: begin
                res_status_q <= gapf_pkg::STAT_OK;
                comp_q  <= '0;
                art_q   <= '0;
                r_q     <= NW'(1);
                state_q <= ST_SWEEP;
              end
              gapf_pkg::OP_QUERY: begin
                if (!computed_q) begin
                  res_status_q <= gapf_pkg::STAT_NOCOMP;
                  state_q      <= ST_DONE;
                end else if (!a_ok) begin
                  res_status_q <= gapf_pkg::STAT_RANGE;
                  state_q      <= ST_DONE;
                end else begin
                  res_status_q <= gapf_pkg::STAT_OK;
                  state_q      <= ST_QRY;
                end
              end
              default: begin
                res_status_q <= gapf_pkg::STAT_OK;
                state_q      <= ST_DONE;
              end
            endcase
          end
        end
        ST_ADD1: state_q <= ST_ADD2;
        ST_ADD2: state_q <= ST_ADD3;
        ST_ADD3: begin
          fill_q     <= PW'(fill_next);
          computed_q <= 1'b0;
          state_q    <= ST_DONE;
        end
        ST_QRY: begin
          res_root_q <= nr_root;
          res_art_q  <= (nr_mark == gapf_pkg::MK_ART);
          state_q    <= ST_DONE;
        end
        ST_SWEEP: begin
          if (r_q > n_nw) begin
            r_q     <= NW'(1);
            state_q <= ST_S0;
          end else begin
            r_q <= r_q + NW'(1);
          end
        end
        ST_S0: begin
          if (r_q > n_nw) begin
            computed_q <= 1'b1;
            state_q    <= ST_DONE;
          end else begin
            state_q <= ST_S1;
          end
        end
        ST_S1: begin
          if (nr_mark != gapf_pkg::MK_FREE) begin
            r_q     <= r_q + NW'(1);
            state_q <= ST_S0;
          end else begin
            // open a new component at this root
            comp_q  <= comp_q + NW'(1);
            v_q     <= r_q;
            p_q     <= h_rd;
            mk_q    <= gapf_pkg::MK_VIS;
            rt_q    <= 1'b1;
            dv_q    <= '0;
            lv_q    <= '0;
            rc_q    <= '0;
            sp_q    <= '0;
            state_q <= ST_E0;
          end
        end
        ST_E0: begin
          if (p_empty) begin
            if (sp_q == '0) begin
              if (root_mark != mk_q) art_q <= art_q + NW'(1);
              r_q     <= r_q + NW'(1);
              state_q <= ST_S0;
            end else begin
              sp_q    <= sp_q - SAW'(1);
              state_q <= ST_P1;
            end
          end else begin
            state_q <= ST_E1;
          end
        end
        ST_E1: begin
          p_q     <= e_link;
          w_q     <= e_nb;
          state_q <= w_ok ? ST_E2 : ST_E0;
        end
        ST_E2: begin
          if (do_push) begin
            sp_q <= sp_q + SAW'(1);
            v_q  <= w_q;
            p_q  <= h_rd;
            mk_q <= gapf_pkg::MK_VIS;
            rt_q <= 1'b0;
            dv_q <= dv_q + NW'(1);
            lv_q <= dv_q + NW'(1);
          end else if (w_mark != gapf_pkg::MK_FREE && w_dep < lv_q) begin
            lv_q <= w_dep;
          end
          state_q <= ST_E0;
        end
        ST_P1: begin
          // step back to the parent, keep the child's low value
          v_q     <= s_rd[PW +: NW];
          p_q     <= s_rd[PW-1:0];
          clow_q  <= lv_q;
          state_q <= ST_P2;
        end
        ST_P2: begin
          mk_q <= (!nr_root && clow_q >= nr_dep && nr_mark == gapf_pkg::MK_VIS) ?
                  gapf_pkg::MK_ART : nr_mark;
          rt_q <= nr_root;
          dv_q <= nr_dep;
          lv_q <= (nr_low < clow_q) ? nr_low : clow_q;
          if (nr_root) begin
            if (!rc_q[1]) rc_q <= rc_q + 2'd1;
          end else if (clow_q >= nr_dep && nr_mark == gapf_pkg::MK_VIS) begin
            art_q <= art_q + NW'(1);
          end
          state_q <= ST_E0;
        end
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            status_q    <= res_status_q;
            ccount_q    <= computed_q ? 11'(comp_q) : 11'd0;
            acount_q    <= computed_q ? 11'(art_q) : 11'd0;
            oroot_q     <= res_root_q;
            oart_q      <= res_art_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
      if (psel && penable && pwrite && !paddr[2]) begin
        node_count_q <= pwdata[10:0];
        computed_q   <= 1'b0;
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {21'd0, node_count_q};

  assign in_stall_o           = (state_q != ST_IDLE);
  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign component_count_o    = ccount_q;
  assign articulation_count_o = acount_q;
  assign is_component_root_o  = oroot_q;
  assign is_articulation_o    = oart_q;

`ifndef SYNTHESIS
  a_query_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && op_i == gapf_pkg::OP_QUERY && computed_q && a_ok) |=> state_q == ST_QRY)
    else $error("query did not go to node read");
  a_fill_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fill_q[0] && fill_q <= PW'(SLOTS))
    else $error("edge fill out of step");
  a_push_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_E2 && do_push) |=> dv_q == $past(dv_q) + NW'(1))
    else $error("push did not deepen walk");
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside done");
`endif

endmodule

### sim/gapf_checker.sv
// ----------------------------------------------------------------------------
// gapf_checker
// Watches the register port and both word channels of the articulation point
// finder, keeps its own copy of the graph and the walk results, and compares
// every result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module gapf_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [10:0] node_a_i,
  input  logic [10:0] node_b_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [1:0]  status_o,
  input  logic [10:0] component_count_o,
  input  logic [10:0] articulation_count_o,
  input  logic        is_component_root_o,
  input  logic        is_articulation_o,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int NODES = 1024;
  localparam int SLOTS = 8192;
  localparam logic [13:0] EMPTY = 14'(SLOTS);
  localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] comps;
    logic [10:0] arts;
    logic        is_root;
    logic        is_art;
  } answer_t;

  answer_t answer_q[$];

  logic [10:0] cfg_nodes;
  logic [10:0] nbr_mem [SLOTS];
  logic [13:0] link_mem [SLOTS];
  logic [13:0] head_mem [NODES+1];
  logic [13:0] fill;
  logic [1:0]  mark [NODES+1];
  logic [10:0] dep [NODES+1];
  logic [10:0] lowv [NODES+1];
  logic        rootf [NODES+1];
  logic [10:0] stk_node [NODES];
  logic [13:0] stk_ptr [NODES];
  logic [10:0] comps, arts;
  logic        done_flag;
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = answer_q.size();

  function automatic int active_n();
    return (cfg_nodes > NODES) ? NODES : int'(cfg_nodes);
  endfunction

  function automatic bit valid_node(logic [10:0] v);
    return v >= 1 && int'(v) <= active_n();
  endfunction

  task automatic wipe_graph();
    for (int i = 0; i <= NODES; i++) begin
      head_mem[i] = EMPTY;
      mark[i] = gapf_pkg::MK_FREE;
      rootf[i] = 1'b0;
    end
    fill = '0;
    comps = '0;
    arts = '0;
    done_flag = 1'b0;
  endtask

  task automatic flag_art(int v);
    if (mark[v] == gapf_pkg::MK_VIS) begin
      mark[v] = gapf_pkg::MK_ART;
      arts++;
    end
  endtask

  task automatic walk_all();
    int n, sp, kids, v, w, q;
    logic [13:0] p;
    n = active_n();
    for (int i = 0; i <= NODES; i++) begin
      mark[i] = gapf_pkg::MK_FREE;
      rootf[i] = 1'b0;
    end
    comps = '0;
    arts = '0;
    for (int r = 1; r <= n; r++) begin
      if (mark[r] != gapf_pkg::MK_FREE) continue;
      comps++;
      rootf[r] = 1'b1;
      mark[r] = gapf_pkg::MK_VIS;
      dep[r] = '0;
      lowv[r] = '0;
      kids = 0;
      stk_node[0] = 11'(r);
      stk_ptr[0] = head_mem[r];
      sp = 1;
      while (sp > 0) begin
        v = stk_node[sp-1];
        p = stk_ptr[sp-1];
        if (p < EMPTY) begin
          w = nbr_mem[p];
          stk_ptr[sp-1] = link_mem[p];
          if (w < 1 || w > n) continue;
          if (mark[w] == gapf_pkg::MK_FREE) begin
            if (sp >= NODES) continue;
            mark[w] = gapf_pkg::MK_VIS;
            dep[w] = dep[v] + 11'd1;
            lowv[w] = dep[w];
            stk_node[sp] = 11'(w);
            stk_ptr[sp] = head_mem[w];
            sp++;
          end else if (dep[w] < lowv[v]) begin
            lowv[v] = dep[w];
          end
        end else begin
          sp--;
          if (sp > 0) begin
            q = stk_node[sp-1];
            if (lowv[v] < lowv[q]) lowv[q] = lowv[v];
            if (q == r) kids++;
            else if (lowv[v] >= dep[q]) flag_art(q);
          end
        end
      end
      if (kids >= 2) flag_art(r);
    end
    done_flag = 1'b1;
  endtask

  task automatic predict_word(logic [1:0] op, logic [10:0] a, logic [10:0] b);
    answer_t e;
    e = '0;
    case (op)
      gapf_pkg::OP_CLEAR: wipe_graph();
      gapf_pkg::OP_ADD: begin
        if (!valid_node(a) || !valid_node(b)) begin
          e.status = gapf_pkg::STAT_RANGE;
        end else if (int'(fill) + 2 > SLOTS) begin
          e.status = gapf_pkg::STAT_FULL;
        end else begin
          nbr_mem[fill] = b;
          link_mem[fill] = head_mem[a];
          head_mem[a] = fill;
          nbr_mem[fill+1] = a;
          link_mem[fill+1] = head_mem[b];
          head_mem[b] = fill + 14'd1;
          fill = fill + 14'd2;
          done_flag = 1'b0;
        end
      end
      gapf_pkg::OP_COMPUTE: walk_all();
      default: begin
        if (!done_flag) e.status = gapf_pkg::STAT_NOCOMP;
        else if (!valid_node(a)) e.status = gapf_pkg::STAT_RANGE;
        else begin
          e.is_root = rootf[a];
          e.is_art = (mark[a] == gapf_pkg::MK_ART);
        end
      end
    endcase
    if (done_flag) begin
      e.comps = comps;
      e.arts = arts;
    end
    answer_q = {answer_q, e};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      cfg_nodes = 11'd1;
      wipe_graph();
      answer_q.delete();
      fails = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_NODE_COUNT) begin
        cfg_nodes = pwdata[10:0];
        done_flag = 1'b0;
      end
      if (out_valid_o && !out_stall_i) begin
        got = '{status_o, component_count_o, articulation_count_o,
                is_component_root_o, is_articulation_o};
        if (answer_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result word %p", got);
        end else begin
          want = answer_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_o) predict_word(op_i, node_a_i, node_b_i);
    end
  end

endmodule

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives edge loads, computes and queries into the articulation point finder
// with random gaps and receiver stalls, reprograms the node count between
// phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 6000000;
  localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  op_i = gapf_pkg::OP_CLEAR;
  logic [10:0] node_a_i = '0, node_b_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [10:0] component_count_o, articulation_count_o;
  logic        is_component_root_o, is_articulation_o;
  int          fail_count, pending;
  int          cycles = 0;
  int          words_sent = 0;
  bit          hold_req = 1'b0;
  bit          no_gaps = 1'b0;
  int          cur_n = 1;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  graph_articulation_point_finder_core dut (.*);

  gapf_checker u_checker (
    .*, .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    if (no_gaps) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 150);
    return $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int len;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (800) @(negedge clk_i);
        hold_req = 1'b0;
      end
      len = pick_gap();
      out_stall_i = (len != 0);
      repeat (len) @(negedge clk_i);
      out_stall_i = 1'b0;
    end
  end

  task automatic send(logic [1:0] op, logic [10:0] a, logic [10:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i = op;
    node_a_i = a;
    node_b_i = b;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic set_nodes(int n);
    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (10) @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = ADDR_NODE_COUNT;
    pwdata = 32'(n);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    cur_n = n;
  endtask

  function automatic logic [10:0] rand_node();
    int m;
    m = (cur_n > 1024) ? 1024 : cur_n;
    if (m < 1) return 11'd1;
    return 11'($urandom_range(1, m));
  endfunction

  task automatic query_all(int m);
    for (int v = 0; v <= m + 1; v++) send(gapf_pkg::OP_QUERY, 11'(v), 11'($urandom));
  endtask

  initial begin
    int n, k;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: query before compute, bad endpoints, loops, parallel edges
    set_nodes(5);
    send(gapf_pkg::OP_QUERY, 11'd3, 11'd0);
    send(gapf_pkg::OP_ADD, 11'd0, 11'd2);
    send(gapf_pkg::OP_ADD, 11'd1, 11'd6);
    send(gapf_pkg::OP_ADD, 11'd2047, 11'd2047);
    send(gapf_pkg::OP_ADD, 11'd2, 11'd2);
    send(gapf_pkg::OP_ADD, 11'd1, 11'd2);
    send(gapf_pkg::OP_ADD, 11'd1, 11'd2);
    send(gapf_pkg::OP_ADD, 11'd2, 11'd3);
    send(gapf_pkg::OP_ADD, 11'd3, 11'd4);
    send(gapf_pkg::OP_COMPUTE, 11'd0, 11'd0);
    // hold the receiver off while queries keep coming
    hold_req = 1'b1;
    query_all(5);
    send(gapf_pkg::OP_QUERY, 11'd2047, 11'd2047);
    send(gapf_pkg::OP_ADD, 11'd4, 11'd5);
    send(gapf_pkg::OP_QUERY, 11'd4, 11'd0);
    // shrink the node count below stored neighbors
    set_nodes(3);
    send(gapf_pkg::OP_COMPUTE, 11'd0, 11'd0);
    send(gapf_pkg::OP_QUERY, 11'd4, 11'd0);
    send(gapf_pkg::OP_QUERY, 11'd2, 11'd0);
    set_nodes(0);
    send(gapf_pkg::OP_COMPUTE, 11'd0, 11'd0);
    send(gapf_pkg::OP_QUERY, 11'd1, 11'd0);
    send(gapf_pkg::OP_ADD, 11'd1, 11'd1);

    // full node range: endpoints above the node limit are rejected
    set_nodes(2047);
    send(gapf_pkg::OP_CLEAR, 11'd0, 11'd0);
    no_gaps = 1'b1;
    for (int i = 0; i < 40; i++) send(gapf_pkg::OP_ADD, rand_node(), rand_node());
    send(gapf_pkg::OP_ADD, 11'd1024, 11'd1);
    send(gapf_pkg::OP_ADD, 11'd1025, 11'd1);
    no_gaps = 1'b0;
    send(gapf_pkg::OP_COMPUTE, 11'd0, 11'd0);
    send(gapf_pkg::OP_QUERY, 11'd1024, 11'd0);
    send(gapf_pkg::OP_QUERY, 11'd1025, 11'd0);
    set_nodes(1024);
    send(gapf_pkg::OP_CLEAR, 11'd0, 11'd0);

    while (words_sent < 950) begin
      k = $urandom_range(0, 19);
      n = (k == 0) ? 0 : (k == 1) ? 1024 : (k == 2) ? 2047 : (k == 3) ? 1
        : $urandom_range(2, 14);
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) < 7) set_nodes(n);
      if ($urandom_range(0, 9) < 7)
        send(gapf_pkg::OP_CLEAR, 11'($urandom), 11'($urandom));
      n = (cur_n > 1024) ? 1024 : cur_n;
      k = (n > 14) ? $urandom_range(0, 30) : $urandom_range(0, 2 * n + 1);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0)
          send(2'($urandom), 11'($urandom), 11'($urandom));
        else
          send(gapf_pkg::OP_ADD, rand_node(), rand_node());
      end
      send(gapf_pkg::OP_COMPUTE, 11'($urandom), 11'($urandom));
      if ($urandom_range(0, 3) == 0) hold_req = 1'b1;
      if (n > 14) begin
        for (int i = 0; i < 12; i++)
          send(gapf_pkg::OP_QUERY, 11'($urandom), 11'($urandom));
        send(gapf_pkg::OP_QUERY, 11'(n), 11'd0);
      end else begin
        query_all(n);
      end
      if ($urandom_range(0, 4) == 0) begin
        send(gapf_pkg::OP_ADD, rand_node(), rand_node());
        send(gapf_pkg::OP_QUERY, rand_node(), 11'd0);
      end
    end

    in_valid_i = 1'b0;
    wait (pending == 0);
    repeat (2000) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/gapf_pkg.sv
hw/rtl/graph_articulation_point_finder_core.sv
sim/gapf_checker.sv
sim/testbench.sv
